// ===== sv/isgb_pkg.sv =====
// shared constants, types and scaling functions for the imu sample scaler
package isgb_pkg;

    localparam int CAL_SAMPLES = 256;
    localparam int NUM_AXES    = 3;
    localparam int WORD_W      = 16;
    localparam int TEMP_W      = 9;
    localparam int IN_DATA_W   = 112;
    localparam int OUT_DATA_W  = 112;
    localparam int CFG_IDX_W   = 2;

    // calibration accumulator and counter sizing
    localparam int CAL_LOG = $clog2(CAL_SAMPLES);
    localparam int CNT_W   = (CAL_SAMPLES > 1) ? CAL_LOG : 1;
    localparam int SUM_W   = WORD_W + CAL_LOG;

    // sum / CAL_SAMPLES through a reciprocal, exact for |sum| <= CAL_SAMPLES * 2^15
    localparam int DIV_SH = 15 + 2 * CAL_LOG;
    localparam longint unsigned DIV_K =
        ((64'd1 << DIV_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam int DIV_PW = SUM_W + DIV_SH - CAL_LOG + 2;

    // accel: raw * 488 / 1000 rounded == (122 * |raw| + 125) / 250, via reciprocal
    localparam int ACC_SH = 30;
    localparam longint unsigned ACC_K   = ((64'd1 << ACC_SH) + 64'd249) / 64'd250;
    localparam longint unsigned ACC_MUL = 64'd122 * ACC_K;
    localparam longint unsigned ACC_ADD = 64'd125 * ACC_K;
    localparam int ACC_PW = 48;

    // gyro: raw * 875 / 100 == raw * 35 / 4
    localparam int GYR_MUL = 35;
    localparam int GYR_PW  = 21;

    localparam int TEMP_OFFSET = 25;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [TEMP_W-1:0] temp_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_EN = 2'd0,
        REG_GYRO_EN  = 2'd1,
        REG_TEMP_EN  = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic load;   // beat enters the scaling stage
        logic adv;    // scaling stage moves into the output stage
        logic cal;    // beat in the scaling stage is a calibration sample
        logic last;   // that beat closes the calibration run
    } lane_ctrl_t;

    function automatic logic [WORD_W:0] mag17(input word_t raw);
        logic [WORD_W:0] r;
        r = {raw[WORD_W-1], raw};
        return raw[WORD_W-1] ? (~r + 17'd1) : r;
    endfunction

    function automatic word_t accel_scale(input word_t raw);
        logic [WORD_W:0]   mag;
        logic [ACC_PW-1:0] prod;
        logic [WORD_W-1:0] q;
        mag  = mag17(raw);
        prod = ACC_PW'(mag) * ACC_PW'(ACC_MUL) + ACC_PW'(ACC_ADD);
        q    = prod[ACC_SH +: WORD_W];
        return raw[WORD_W-1] ? word_t'(~q + 16'd1) : word_t'(q);
    endfunction

    function automatic word_t gyro_scale(input word_t raw);
        logic [WORD_W:0]   mag;
        logic [GYR_PW-1:0] m;
        logic [GYR_PW-3:0] q;
        word_t             res;
        mag = mag17(raw);
        m   = GYR_PW'(mag) * GYR_PW'(GYR_MUL);
        q   = (GYR_PW-2)'((m + GYR_PW'(2)) >> 2);
        if (!raw[WORD_W-1]) begin
            res = (q > (GYR_PW-2)'(32767)) ? 16'sh7FFF : word_t'(q[WORD_W-1:0]);
        end else begin
            res = (q > (GYR_PW-2)'(32768)) ? 16'sh8000 : word_t'(~q[WORD_W-1:0] + 16'd1);
        end
        return res;
    endfunction

    function automatic temp_t temp_conv(input word_t raw);
        logic [WORD_W:0]   mag;
        logic [TEMP_W-1:0] tq;
        mag = mag17(raw);
        tq  = TEMP_W'((mag + 17'd128) >> 8);
        return raw[WORD_W-1] ? temp_t'(TEMP_W'(TEMP_OFFSET) - tq)
                             : temp_t'(TEMP_W'(TEMP_OFFSET) + tq);
    endfunction

endpackage

// ===== sv/isgb_accel_lane.sv =====
// one accel axis: scaling to milli-g into the first stage register
module isgb_accel_lane (
    input  logic                    aclk,
    input  isgb_pkg::lane_ctrl_t    ctrl,
    input  logic                    enable,
    input  isgb_pkg::word_t         raw,
    output isgb_pkg::word_t         scaled
);

    isgb_pkg::word_t scaled_reg;
    isgb_pkg::word_t scaled_next;

    always_comb begin
        scaled_next = enable ? isgb_pkg::accel_scale(raw) : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

// ===== sv/isgb_gyro_lane.sv =====
// one gyro axis: scaling, bias subtraction and the calibration accumulator
module isgb_gyro_lane (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  isgb_pkg::lane_ctrl_t    ctrl,
    input  logic                    enable,
    input  isgb_pkg::word_t         raw,
    output isgb_pkg::word_t         corrected
);

    isgb_pkg::word_t                   scaled_reg;
    isgb_pkg::word_t                   scaled_next;
    isgb_pkg::word_t                   bias_reg;
    isgb_pkg::word_t                   bias_next;
    logic signed [isgb_pkg::SUM_W-1:0] sum_reg;
    logic signed [isgb_pkg::SUM_W-1:0] sum_next;
    logic signed [isgb_pkg::SUM_W-1:0] sum_add;
    logic [isgb_pkg::SUM_W-1:0]        sum_mag;
    logic [isgb_pkg::DIV_PW-1:0]       div_prod;
    logic [isgb_pkg::WORD_W-1:0]       div_q;
    logic [isgb_pkg::WORD_W:0]         diff;

    always_comb begin
        scaled_next = enable ? isgb_pkg::gyro_scale(raw) : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            scaled_reg <= scaled_next;
        end
    end

    // output: scaled minus bias, clamped to int16
    always_comb begin
        diff = {scaled_reg[isgb_pkg::WORD_W-1], scaled_reg}
             - {bias_reg[isgb_pkg::WORD_W-1], bias_reg};
        if (diff[isgb_pkg::WORD_W] != diff[isgb_pkg::WORD_W-1]) begin
            corrected = diff[isgb_pkg::WORD_W] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            corrected = isgb_pkg::word_t'(diff[isgb_pkg::WORD_W-1:0]);
        end
    end

    // running sum and truncating divide of the closing sum
    always_comb begin
        sum_add  = sum_reg + {{(isgb_pkg::SUM_W-isgb_pkg::WORD_W){scaled_reg[isgb_pkg::WORD_W-1]}},
                              scaled_reg};
        sum_mag  = sum_add[isgb_pkg::SUM_W-1] ? (~sum_add + 1'b1) : sum_add;
        div_prod = isgb_pkg::DIV_PW'(sum_mag) * isgb_pkg::DIV_PW'(isgb_pkg::DIV_K);
        div_q    = div_prod[isgb_pkg::DIV_SH +: isgb_pkg::WORD_W];
        sum_next  = sum_reg;
        bias_next = bias_reg;
        if (ctrl.adv && ctrl.cal) begin
            if (ctrl.last) begin
                sum_next  = '0;
                bias_next = sum_add[isgb_pkg::SUM_W-1] ? isgb_pkg::word_t'(~div_q + 16'd1)
                                                        : isgb_pkg::word_t'(div_q);
            end else begin
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            bias_reg <= '0;
        end else begin
            sum_reg  <= sum_next;
            bias_reg <= bias_next;
        end
    end

endmodule

// ===== sv/isgb_merge.sv =====
// output stage: gathers the lane results into the result beat register
module isgb_merge (
    input  logic                                   aclk,
    input  logic                                   adv,
    input  isgb_pkg::word_t [isgb_pkg::NUM_AXES-1:0] accel,
    input  isgb_pkg::word_t [isgb_pkg::NUM_AXES-1:0] gyro,
    input  isgb_pkg::temp_t                        temp,
    input  logic                                   done,
    output logic [isgb_pkg::OUT_DATA_W-1:0]        tdata,
    output logic                                   tuser
);

    isgb_pkg::word_t [isgb_pkg::NUM_AXES-1:0] accel_reg;
    isgb_pkg::word_t [isgb_pkg::NUM_AXES-1:0] gyro_reg;
    isgb_pkg::temp_t                          temp_reg;
    logic                                     done_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            accel_reg <= accel;
            gyro_reg  <= gyro;
            temp_reg  <= temp;
            done_reg  <= done;
        end
    end

    localparam int PAD_W = isgb_pkg::OUT_DATA_W - 2 * isgb_pkg::NUM_AXES * isgb_pkg::WORD_W
                         - isgb_pkg::TEMP_W;

    assign tdata = {{PAD_W{1'b0}}, temp_reg, gyro_reg, accel_reg};
    assign tuser = done_reg;

endmodule

// ===== sv/imu_sample_scaler_gyro_bias_unit.sv =====
// top level of the imu sample scaler with gyro bias calibration
//
//  channel  | ports                    | contents
//  ---------+--------------------------+---------------------------------------------
//  input    | s_tvalid/s_tready/tdata  | one imu frame per beat, tuser = opcode
//  result   | m_tvalid/m_tready/tdata  | scaled frame per beat, tuser = calibration_done
//  config   | cfg_we/cfg_index/cfg_data| enable bits, taken on any edge with cfg_we
//
//  one beat per cycle sustained while m_tready holds; each input beat goes through
//  the scaling stage, then the output stage where bias subtraction and the calibration
//  accumulator close their loop, on its way to a result beat
//  synchronous active-low reset clears bias, sums, count, valids; enables go to 1
//  a stalled result holds the output stage; the scaling stage still takes one beat
module imu_sample_scaler_gyro_bias_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // raw_temp, raw_gyro_x, raw_gyro_y, raw_gyro_z, raw_accel_x, raw_accel_y, raw_accel_z
    input  logic [isgb_pkg::IN_DATA_W-1:0]     s_tdata,
    // opcode
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // accel_x_mg, accel_y_mg, accel_z_mg, gyro_x_mdps, gyro_y_mdps, gyro_z_mdps,
    // temp_celsius, zero padding
    output logic [isgb_pkg::OUT_DATA_W-1:0]    m_tdata,
    // calibration_done
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_we,
    input  logic [isgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [0:0]                         cfg_data
);

    logic                          accel_en_reg, accel_en_next;
    logic                          gyro_en_reg, gyro_en_next;
    logic                          temp_en_reg, temp_en_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_cal_reg, s1_cal_next;
    logic                          m_valid_reg, m_valid_next;
    logic [isgb_pkg::CNT_W-1:0]    cal_count_reg, cal_count_next;
    isgb_pkg::temp_t               temp_reg, temp_next;
    logic                          accept;
    logic                          adv;
    logic                          cal_last;
    isgb_pkg::lane_ctrl_t          ctrl;

    isgb_pkg::word_t [isgb_pkg::NUM_AXES-1:0] accel_lane;
    isgb_pkg::word_t [isgb_pkg::NUM_AXES-1:0] gyro_lane;

    // handshake and stage control
    assign adv      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;
    assign accept   = s_tvalid && s_tready;
    assign cal_last = (cal_count_reg == isgb_pkg::CNT_W'(isgb_pkg::CAL_SAMPLES - 1));
    assign m_tvalid = m_valid_reg;

    always_comb begin
        ctrl.load = accept;
        ctrl.adv  = adv;
        ctrl.cal  = s1_cal_reg;
        ctrl.last = cal_last;
    end

    always_comb begin
        s1_valid_next  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        s1_cal_next    = accept ? s_tuser[0] : s1_cal_reg;
        m_valid_next   = adv ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        cal_count_next = cal_count_reg;
        if (adv && s1_cal_reg) begin
            cal_count_next = cal_last ? '0 : cal_count_reg + 1'b1;
        end
        temp_next = temp_reg;
        if (accept) begin
            temp_next = temp_en_reg ? isgb_pkg::temp_conv(s_tdata[isgb_pkg::WORD_W-1:0]) : '0;
        end
    end

    // register decode
    always_comb begin
        accel_en_next = accel_en_reg;
        gyro_en_next  = gyro_en_reg;
        temp_en_next  = temp_en_reg;
        if (cfg_we) begin
            unique case (isgb_pkg::cfg_reg_e'(cfg_index))
                isgb_pkg::REG_ACCEL_EN: accel_en_next = cfg_data[0];
                isgb_pkg::REG_GYRO_EN:  gyro_en_next  = cfg_data[0];
                isgb_pkg::REG_TEMP_EN:  temp_en_next  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_en_reg  <= 1'b1;
            gyro_en_reg   <= 1'b1;
            temp_en_reg   <= 1'b1;
            s1_valid_reg  <= 1'b0;
            s1_cal_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            cal_count_reg <= '0;
        end else begin
            accel_en_reg  <= accel_en_next;
            gyro_en_reg   <= gyro_en_next;
            temp_en_reg   <= temp_en_next;
            s1_valid_reg  <= s1_valid_next;
            s1_cal_reg    <= s1_cal_next;
            m_valid_reg   <= m_valid_next;
            cal_count_reg <= cal_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        temp_reg <= temp_next;
    end

    // one lane per axis for gyro and accel
    for (genvar i = 0; i < isgb_pkg::NUM_AXES; i++) begin : g_axis
        isgb_gyro_lane u_gyro (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .enable    (gyro_en_reg),
            .raw       (s_tdata[isgb_pkg::WORD_W*(1+i) +: isgb_pkg::WORD_W]),
            .corrected (gyro_lane[i])
        );

        isgb_accel_lane u_accel (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .enable (accel_en_reg),
            .raw    (s_tdata[isgb_pkg::WORD_W*(1+isgb_pkg::NUM_AXES+i) +: isgb_pkg::WORD_W]),
            .scaled (accel_lane[i])
        );
    end

    isgb_merge u_merge (
        .aclk  (aclk),
        .adv   (adv),
        .accel (accel_lane),
        .gyro  (gyro_lane),
        .temp  (temp_reg),
        .done  (s1_cal_reg && cal_last),
        .tdata (m_tdata),
        .tuser (m_tuser[0])
    );

    // the input side only stalls when both stages are full and the output is held
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled with a free stage");

    a_adv_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_valid_reg)
        else $error("output stage empty after a transfer");

    a_run_end_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s1_cal_reg && cal_last) |=> (cal_count_reg == '0))
        else $error("calibration count not cleared at end of run");

endmodule
